@@ rtl/pto_pkg.sv @@
`timescale 1ns / 1ps
// shared constants, codes and control structs for the order book
// no dependencies
package pto_pkg;

   localparam int ORDER_SLOTS_DEF = 64;
   localparam int PRICE_BITS_DEF  = 32;
   localparam int QTY_BITS_DEF    = 32;

   localparam int FIELD_W = 32;
   localparam int COUNT_W = 7;
   localparam int ARR_W   = 32;

   // request commands
   localparam logic [2:0] CMD_ADD       = 3'd0;
   localparam logic [2:0] CMD_CANCEL    = 3'd1;
   localparam logic [2:0] CMD_SWEEP_BID = 3'd2;
   localparam logic [2:0] CMD_SWEEP_ASK = 3'd3;
   localparam logic [2:0] CMD_DEPTH     = 3'd4;

   // result kinds
   localparam logic [2:0] KIND_ADD_OK  = 3'd0;
   localparam logic [2:0] KIND_ADD_REJ = 3'd1;
   localparam logic [2:0] KIND_CANCEL  = 3'd2;
   localparam logic [2:0] KIND_FILL    = 3'd3;
   localparam logic [2:0] KIND_DEPTH   = 3'd4;
   localparam logic [2:0] KIND_EMPTY   = 3'd5;

   // slot scan flavors
   localparam logic [2:0] SCAN_ADD    = 3'd0;
   localparam logic [2:0] SCAN_CANCEL = 3'd1;
   localparam logic [2:0] SCAN_SWEEP  = 3'd2;
   localparam logic [2:0] SCAN_DEPTH  = 3'd3;
   localparam logic [2:0] SCAN_BEST   = 3'd4;

   // result-producing actions
   localparam logic [2:0] ACT_NONE   = 3'd0;
   localparam logic [2:0] ACT_ADD    = 3'd1;
   localparam logic [2:0] ACT_CANCEL = 3'd2;
   localparam logic [2:0] ACT_FILL   = 3'd3;
   localparam logic [2:0] ACT_DEPTH  = 3'd4;
   localparam logic [2:0] ACT_EMPTY  = 3'd5;

   typedef struct packed {
      logic       capture;
      logic       scan_start;
      logic [2:0] scan_mode;
      logic [2:0] act;
      logic       rd_issue;
      logic       out_load;
   } pto_cmd_type;

   typedef struct packed {
      logic [2:0] cmd;
      logic       scan_done;
      logic       hit;
      logic       want_zero;
      logic       n_zero;
      logic       n_full;
      logic       lvl_done;
      logic       emit_last;
      logic       out_free;
   } pto_sts_type;

   typedef struct packed {
      logic [2:0]         kind;
      logic [FIELD_W-1:0] oid;
      logic [FIELD_W-1:0] cid;
      logic [FIELD_W-1:0] price;
      logic [FIELD_W-1:0] qty;
      logic [COUNT_W-1:0] count;
      logic               found;
   } pto_res_type;

endpackage

@@ rtl/pto_ctrl.sv @@
`timescale 1ns / 1ps
// sequencer for the order book: runs slot scans, actions and result beats
// depends on pto_pkg
module pto_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  pto_pkg::pto_sts_type sts,
   output pto_pkg::pto_cmd_type ctl
);

   localparam logic [3:0] S_IDLE      = 4'd0;
   localparam logic [3:0] S_DISP      = 4'd1;
   localparam logic [3:0] S_ADD_SCAN  = 4'd2;
   localparam logic [3:0] S_ADD_FIN   = 4'd3;
   localparam logic [3:0] S_CAN_SCAN  = 4'd4;
   localparam logic [3:0] S_CAN_FIN   = 4'd5;
   localparam logic [3:0] S_SW_CHK    = 4'd6;
   localparam logic [3:0] S_SW_SCAN   = 4'd7;
   localparam logic [3:0] S_SW_FILL   = 4'd8;
   localparam logic [3:0] S_DP_CHK    = 4'd9;
   localparam logic [3:0] S_DP_SCAN   = 4'd10;
   localparam logic [3:0] S_DP_PUSH   = 4'd11;
   localparam logic [3:0] S_BEST      = 4'd12;
   localparam logic [3:0] S_BEST_SCAN = 4'd13;
   localparam logic [3:0] S_EM_RD     = 4'd14;
   localparam logic [3:0] S_EM_LD     = 4'd15;

   logic [3:0] state_ff;
   logic [3:0] state_in;

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in       = state_ff;
      ctl            = '0;
      ctl.scan_mode  = pto_pkg::SCAN_ADD;
      ctl.act        = pto_pkg::ACT_NONE;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               ctl.capture = 1'b1;
               state_in    = S_DISP;
            end
         end
         S_DISP: begin
            unique case (sts.cmd)
               pto_pkg::CMD_ADD: begin
                  ctl.scan_start = 1'b1;
                  ctl.scan_mode  = pto_pkg::SCAN_ADD;
                  state_in       = S_ADD_SCAN;
               end
               pto_pkg::CMD_CANCEL: begin
                  ctl.scan_start = 1'b1;
                  ctl.scan_mode  = pto_pkg::SCAN_CANCEL;
                  state_in       = S_CAN_SCAN;
               end
               pto_pkg::CMD_SWEEP_BID, pto_pkg::CMD_SWEEP_ASK: state_in = S_SW_CHK;
               pto_pkg::CMD_DEPTH: state_in = S_DP_CHK;
               default: begin
                  ctl.act  = pto_pkg::ACT_EMPTY;
                  state_in = S_BEST;
               end
            endcase
         end
         S_ADD_SCAN: if (sts.scan_done) state_in = S_ADD_FIN;
         S_ADD_FIN: begin
            ctl.act  = pto_pkg::ACT_ADD;
            state_in = S_BEST;
         end
         S_CAN_SCAN: if (sts.scan_done) state_in = S_CAN_FIN;
         S_CAN_FIN: begin
            ctl.act  = pto_pkg::ACT_CANCEL;
            state_in = S_BEST;
         end
         S_SW_CHK: begin
            if (sts.want_zero || sts.n_full) begin
               if (sts.n_zero) ctl.act = pto_pkg::ACT_EMPTY;
               state_in = S_BEST;
            end else begin
               ctl.scan_start = 1'b1;
               ctl.scan_mode  = pto_pkg::SCAN_SWEEP;
               state_in       = S_SW_SCAN;
            end
         end
         S_SW_SCAN: if (sts.scan_done) state_in = S_SW_FILL;
         S_SW_FILL: begin
            if (sts.hit) begin
               ctl.act  = pto_pkg::ACT_FILL;
               state_in = S_SW_CHK;
            end else begin
               if (sts.n_zero) ctl.act = pto_pkg::ACT_EMPTY;
               state_in = S_BEST;
            end
         end
         S_DP_CHK: begin
            if (sts.lvl_done || sts.n_full) begin
               if (sts.n_zero) ctl.act = pto_pkg::ACT_EMPTY;
               state_in = S_BEST;
            end else begin
               ctl.scan_start = 1'b1;
               ctl.scan_mode  = pto_pkg::SCAN_DEPTH;
               state_in       = S_DP_SCAN;
            end
         end
         S_DP_SCAN: if (sts.scan_done) state_in = S_DP_PUSH;
         S_DP_PUSH: begin
            if (sts.hit) begin
               ctl.act  = pto_pkg::ACT_DEPTH;
               state_in = S_DP_CHK;
            end else begin
               if (sts.n_zero) ctl.act = pto_pkg::ACT_EMPTY;
               state_in = S_BEST;
            end
         end
         S_BEST: begin
            ctl.scan_start = 1'b1;
            ctl.scan_mode  = pto_pkg::SCAN_BEST;
            state_in       = S_BEST_SCAN;
         end
         S_BEST_SCAN: if (sts.scan_done) state_in = S_EM_RD;
         S_EM_RD: begin
            ctl.rd_issue = 1'b1;
            state_in     = S_EM_LD;
         end
         S_EM_LD: begin
            if (sts.out_free) begin
               ctl.out_load = 1'b1;
               state_in     = sts.emit_last ? S_IDLE : S_EM_RD;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

endmodule

@@ rtl/pto_dpath.sv @@
`timescale 1ns / 1ps
// order book datapath: slot store, scan accumulators, result buffer, output register
// depends on pto_pkg
module pto_dpath #(
   parameter int ORDER_SLOTS = pto_pkg::ORDER_SLOTS_DEF,
   parameter int PRICE_BITS  = pto_pkg::PRICE_BITS_DEF,
   parameter int QTY_BITS    = pto_pkg::QTY_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [2:0]                         req_cmd,
   input  logic                               req_side,
   input  logic [pto_pkg::FIELD_W-1:0]        req_order_id,
   input  logic [pto_pkg::FIELD_W-1:0]        req_client_id,
   input  logic [pto_pkg::FIELD_W-1:0]        req_price,
   input  logic [pto_pkg::FIELD_W-1:0]        req_quantity,
   input  logic [pto_pkg::COUNT_W-1:0]        req_depth_levels,
   input  pto_pkg::pto_cmd_type               ctl,
   output pto_pkg::pto_sts_type               sts,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [2:0]                         rsp_kind,
   output logic [pto_pkg::FIELD_W-1:0]        rsp_order_id_res,
   output logic [pto_pkg::FIELD_W-1:0]        rsp_client_id_res,
   output logic [pto_pkg::FIELD_W-1:0]        rsp_price_res,
   output logic [pto_pkg::FIELD_W-1:0]        rsp_quantity_res,
   output logic [pto_pkg::COUNT_W-1:0]        rsp_level_orders,
   output logic                               rsp_found,
   output logic                               rsp_bid_valid,
   output logic [pto_pkg::FIELD_W-1:0]        rsp_best_bid_price,
   output logic                               rsp_ask_valid,
   output logic [pto_pkg::FIELD_W-1:0]        rsp_best_ask_price,
   output logic                               rsp_last
);

   localparam int IDXW = $clog2(ORDER_SLOTS);
   localparam int CNTW = $clog2(ORDER_SLOTS + 1);
   localparam int AW   = pto_pkg::ARR_W;
   localparam int FW   = pto_pkg::FIELD_W;

   function automatic logic better(input logic sd, input logic [PRICE_BITS-1:0] a,
                                   input logic [PRICE_BITS-1:0] b);
      return sd ? (a < b) : (a > b);
   endfunction

   // captured request
   logic [2:0]                 cmd_q_ff;
   logic                       side_q_ff;
   logic [FW-1:0]              oid_q_ff;
   logic [FW-1:0]              cid_q_ff;
   logic [PRICE_BITS-1:0]      price_q_ff;
   logic [QTY_BITS-1:0]        qty_q_ff;
   logic [QTY_BITS-1:0]        want_ff;
   logic [pto_pkg::COUNT_W-1:0] lvl_q_ff;

   // slot store
   logic [ORDER_SLOTS-1:0]     valid_ff;
   logic                       side_mem  [ORDER_SLOTS];
   logic [FW-1:0]              oid_mem   [ORDER_SLOTS];
   logic [FW-1:0]              cid_mem   [ORDER_SLOTS];
   logic [PRICE_BITS-1:0]      price_mem [ORDER_SLOTS];
   logic [QTY_BITS-1:0]        rem_mem   [ORDER_SLOTS];
   logic [AW-1:0]              arr_mem   [ORDER_SLOTS];
   logic                       rd_side_ff;
   logic [FW-1:0]              rd_oid_ff;
   logic [FW-1:0]              rd_cid_ff;
   logic [PRICE_BITS-1:0]      rd_price_ff;
   logic [QTY_BITS-1:0]        rd_rem_ff;
   logic [AW-1:0]              rd_arr_ff;
   logic [AW-1:0]              arrival_ff;

   // scan engine
   logic                       scan_run_ff;
   logic [IDXW-1:0]            scan_idx_ff;
   logic                       eval_ff;
   logic [IDXW-1:0]            eval_idx_ff;
   logic [2:0]                 mode_ff;

   // accumulators
   logic                       acc_any_ff;
   logic [PRICE_BITS-1:0]      acc_price_ff;
   logic [AW-1:0]              acc_age_ff;
   logic [IDXW-1:0]            acc_idx_ff;
   logic [FW-1:0]              acc_oid_ff;
   logic [FW-1:0]              acc_cid_ff;
   logic [QTY_BITS-1:0]        acc_rem_ff;
   logic [CNTW-1:0]            acc_cnt_ff;
   logic                       dup_ff;
   logic                       free_any_ff;
   logic [IDXW-1:0]            free_idx_ff;
   logic                       found_ff;
   logic                       bid_any_ff;
   logic [PRICE_BITS-1:0]      bid_ff;
   logic                       ask_any_ff;
   logic [PRICE_BITS-1:0]      ask_ff;
   logic [PRICE_BITS-1:0]      prev_ff;

   // result buffer
   pto_pkg::pto_res_type       buf_mem [ORDER_SLOTS];
   pto_pkg::pto_res_type       buf_rd_ff;
   pto_pkg::pto_res_type       push_data;
   logic [CNTW-1:0]            n_ff;
   logic [IDXW-1:0]            emit_idx_ff;

   // evaluation of the slot read last cycle
   logic                       slot_v;
   logic                       side_m;
   logic [AW-1:0]              age;
   logic                       sweep_take;
   logic                       depth_m;
   logic                       depth_new;
   logic                       depth_eq;
   logic [QTY_BITS:0]          sum_wide;
   logic [QTY_BITS-1:0]        sum_sat;
   logic                       cancel_hit;
   logic                       n_zero;
   logic [QTY_BITS-1:0]        take_qty;
   logic                       add_ok;
   logic                       do_add;
   logic                       do_fill;
   logic                       push;

   assign slot_v     = eval_ff && valid_ff[eval_idx_ff];
   assign side_m     = slot_v && (rd_side_ff == side_q_ff);
   assign age        = arrival_ff - rd_arr_ff;
   assign n_zero     = (n_ff == '0);
   assign sweep_take = side_m && (!acc_any_ff || better(side_q_ff, rd_price_ff, acc_price_ff)
                       || (rd_price_ff == acc_price_ff && age > acc_age_ff));
   assign depth_m    = side_m && (n_zero || better(side_q_ff, prev_ff, rd_price_ff));
   assign depth_new  = depth_m && (!acc_any_ff || better(side_q_ff, rd_price_ff, acc_price_ff));
   assign depth_eq   = depth_m && acc_any_ff && (rd_price_ff == acc_price_ff);
   assign sum_wide   = {1'b0, acc_rem_ff} + {1'b0, rd_rem_ff};
   assign sum_sat    = sum_wide[QTY_BITS] ? '1 : sum_wide[QTY_BITS-1:0];
   assign cancel_hit = (mode_ff == pto_pkg::SCAN_CANCEL) && slot_v && (rd_oid_ff == oid_q_ff);

   assign take_qty = (want_ff < acc_rem_ff) ? want_ff : acc_rem_ff;
   assign add_ok   = !dup_ff && free_any_ff && (qty_q_ff != '0);
   assign do_add   = (ctl.act == pto_pkg::ACT_ADD) && add_ok;
   assign do_fill  = (ctl.act == pto_pkg::ACT_FILL);
   assign push     = (ctl.act != pto_pkg::ACT_NONE);

   always_comb begin
      push_data = '0;
      unique case (ctl.act)
         pto_pkg::ACT_ADD: begin
            push_data.kind  = add_ok ? pto_pkg::KIND_ADD_OK : pto_pkg::KIND_ADD_REJ;
            push_data.oid   = oid_q_ff;
            push_data.cid   = cid_q_ff;
            push_data.price = FW'(price_q_ff);
            push_data.qty   = FW'(qty_q_ff);
         end
         pto_pkg::ACT_CANCEL: begin
            push_data.kind  = pto_pkg::KIND_CANCEL;
            push_data.oid   = oid_q_ff;
            push_data.found = found_ff;
         end
         pto_pkg::ACT_FILL: begin
            push_data.kind  = pto_pkg::KIND_FILL;
            push_data.oid   = acc_oid_ff;
            push_data.cid   = acc_cid_ff;
            push_data.price = FW'(acc_price_ff);
            push_data.qty   = FW'(take_qty);
         end
         pto_pkg::ACT_DEPTH: begin
            push_data.kind  = pto_pkg::KIND_DEPTH;
            push_data.price = FW'(acc_price_ff);
            push_data.qty   = FW'(acc_rem_ff);
            push_data.count = pto_pkg::COUNT_W'(acc_cnt_ff);
         end
         pto_pkg::ACT_EMPTY: push_data.kind = pto_pkg::KIND_EMPTY;
         default: push_data = '0;
      endcase
   end

   // request capture
   always_ff @(posedge clock) begin
      if (ctl.capture) begin
         cmd_q_ff   <= req_cmd;
         side_q_ff  <= (req_cmd == pto_pkg::CMD_SWEEP_BID) ? 1'b0 :
                       (req_cmd == pto_pkg::CMD_SWEEP_ASK) ? 1'b1 : req_side;
         oid_q_ff   <= req_order_id;
         cid_q_ff   <= req_client_id;
         price_q_ff <= PRICE_BITS'(req_price);
         qty_q_ff   <= QTY_BITS'(req_quantity);
         lvl_q_ff   <= req_depth_levels;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.capture)  want_ff <= QTY_BITS'(req_quantity);
      else if (do_fill) want_ff <= want_ff - take_qty;
   end

   // valid bits and arrival stamp
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= '0;
         arrival_ff <= '0;
      end else begin
         if (cancel_hit) valid_ff[eval_idx_ff] <= 1'b0;
         if (do_add) begin
            valid_ff[free_idx_ff] <= 1'b1;
            arrival_ff            <= arrival_ff + 1'b1;
         end
         if (do_fill && take_qty == acc_rem_ff) valid_ff[acc_idx_ff] <= 1'b0;
      end
   end

   // slot memories: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (do_add) begin
         side_mem[free_idx_ff]  <= side_q_ff;
         oid_mem[free_idx_ff]   <= oid_q_ff;
         cid_mem[free_idx_ff]   <= cid_q_ff;
         price_mem[free_idx_ff] <= price_q_ff;
         arr_mem[free_idx_ff]   <= arrival_ff;
      end
      if (do_add)       rem_mem[free_idx_ff] <= qty_q_ff;
      else if (do_fill) rem_mem[acc_idx_ff]  <= acc_rem_ff - take_qty;
      rd_side_ff  <= side_mem[scan_idx_ff];
      rd_oid_ff   <= oid_mem[scan_idx_ff];
      rd_cid_ff   <= cid_mem[scan_idx_ff];
      rd_price_ff <= price_mem[scan_idx_ff];
      rd_rem_ff   <= rem_mem[scan_idx_ff];
      rd_arr_ff   <= arr_mem[scan_idx_ff];
   end

   // scan address sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         scan_run_ff <= 1'b0;
         eval_ff     <= 1'b0;
      end else if (ctl.scan_start) begin
         scan_run_ff <= 1'b1;
         eval_ff     <= 1'b0;
      end else begin
         eval_ff <= scan_run_ff;
         if (scan_run_ff && scan_idx_ff == IDXW'(ORDER_SLOTS - 1)) scan_run_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.scan_start) begin
         scan_idx_ff <= '0;
         mode_ff     <= ctl.scan_mode;
      end else if (scan_run_ff) begin
         scan_idx_ff <= scan_idx_ff + 1'b1;
      end
      eval_idx_ff <= scan_idx_ff;
   end

   // accumulators
   always_ff @(posedge clock) begin
      if (reset) begin
         acc_any_ff  <= 1'b0;
         dup_ff      <= 1'b0;
         free_any_ff <= 1'b0;
         found_ff    <= 1'b0;
         bid_any_ff  <= 1'b0;
         ask_any_ff  <= 1'b0;
      end else if (ctl.scan_start) begin
         acc_any_ff  <= 1'b0;
         dup_ff      <= 1'b0;
         free_any_ff <= 1'b0;
         found_ff    <= 1'b0;
         if (ctl.scan_mode == pto_pkg::SCAN_BEST) begin
            bid_any_ff <= 1'b0;
            ask_any_ff <= 1'b0;
         end
      end else if (eval_ff) begin
         unique case (mode_ff)
            pto_pkg::SCAN_ADD: begin
               if (slot_v) begin
                  if (rd_oid_ff == oid_q_ff) dup_ff <= 1'b1;
               end else if (!free_any_ff) begin
                  free_any_ff <= 1'b1;
                  free_idx_ff <= eval_idx_ff;
               end
            end
            pto_pkg::SCAN_CANCEL: if (cancel_hit) found_ff <= 1'b1;
            pto_pkg::SCAN_SWEEP: begin
               if (sweep_take) begin
                  acc_any_ff   <= 1'b1;
                  acc_price_ff <= rd_price_ff;
                  acc_age_ff   <= age;
                  acc_idx_ff   <= eval_idx_ff;
                  acc_oid_ff   <= rd_oid_ff;
                  acc_cid_ff   <= rd_cid_ff;
                  acc_rem_ff   <= rd_rem_ff;
               end
            end
            pto_pkg::SCAN_DEPTH: begin
               if (depth_new) begin
                  acc_any_ff   <= 1'b1;
                  acc_price_ff <= rd_price_ff;
                  acc_rem_ff   <= rd_rem_ff;
                  acc_cnt_ff   <= CNTW'(1);
               end else if (depth_eq) begin
                  acc_rem_ff <= sum_sat;
                  acc_cnt_ff <= acc_cnt_ff + 1'b1;
               end
            end
            pto_pkg::SCAN_BEST: begin
               if (slot_v && !rd_side_ff && (!bid_any_ff || rd_price_ff > bid_ff)) begin
                  bid_any_ff <= 1'b1;
                  bid_ff     <= rd_price_ff;
               end
               if (slot_v && rd_side_ff && (!ask_any_ff || rd_price_ff < ask_ff)) begin
                  ask_any_ff <= 1'b1;
                  ask_ff     <= rd_price_ff;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.act == pto_pkg::ACT_DEPTH) prev_ff <= acc_price_ff;
   end

   // result buffer
   always_ff @(posedge clock) begin
      if (push) buf_mem[n_ff[IDXW-1:0]] <= push_data;
      if (ctl.rd_issue) buf_rd_ff <= buf_mem[emit_idx_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         n_ff        <= '0;
         emit_idx_ff <= '0;
      end else if (ctl.capture) begin
         n_ff        <= '0;
         emit_idx_ff <= '0;
      end else begin
         if (push)         n_ff        <= n_ff + 1'b1;
         if (ctl.out_load) emit_idx_ff <= emit_idx_ff + 1'b1;
      end
   end

   // output register
   logic emit_last;
   assign emit_last = ((32'(emit_idx_ff) + 32'd1) == 32'(n_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else if (ctl.out_load) begin
         rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.out_load) begin
         rsp_kind           <= buf_rd_ff.kind;
         rsp_order_id_res   <= buf_rd_ff.oid;
         rsp_client_id_res  <= buf_rd_ff.cid;
         rsp_price_res      <= buf_rd_ff.price;
         rsp_quantity_res   <= buf_rd_ff.qty;
         rsp_level_orders   <= buf_rd_ff.count;
         rsp_found          <= buf_rd_ff.found;
         rsp_bid_valid      <= bid_any_ff;
         rsp_best_bid_price <= bid_any_ff ? FW'(bid_ff) : '0;
         rsp_ask_valid      <= ask_any_ff;
         rsp_best_ask_price <= ask_any_ff ? FW'(ask_ff) : '0;
         rsp_last           <= emit_last;
      end
   end

   assign sts.cmd       = cmd_q_ff;
   assign sts.scan_done = eval_ff && (eval_idx_ff == IDXW'(ORDER_SLOTS - 1));
   assign sts.hit       = acc_any_ff;
   assign sts.want_zero = (want_ff == '0);
   assign sts.n_zero    = n_zero;
   assign sts.n_full    = (n_ff == CNTW'(ORDER_SLOTS));
   assign sts.lvl_done  = (32'(n_ff) >= 32'(lvl_q_ff));
   assign sts.emit_last = emit_last;
   assign sts.out_free  = !rsp_valid || !rsp_stall;

endmodule

@@ rtl/price_time_order_book_top.sv @@
`timescale 1ns / 1ps
// price-time priority limit order book, top level
// depends on pto_pkg, pto_ctrl and pto_dpath
//
// Bounded two-sided limit order book holding ORDER_SLOTS resting orders. A
// request beat carries one command (add, cancel, sweep bids, sweep asks, depth
// query); the block answers with one or more response beats, the final one
// flagged by rsp_last, and every beat carries the best bid and best ask as
// they stand after the command. Commands run one at a time. Work is done by
// scanning the slot store one slot per clock through a single read port.
// An add or cancel takes one scan followed by its action; a sweep takes one
// scan and one fill action per fill, and one more scan when the side runs out
// before the lots do; a depth query likewise per level, with one more scan
// when the side runs out of levels. Every command then ends with one scan for
// the best prices, and each response beat is read from the result buffer,
// then loaded into the output register, waiting while the consumer stalls.
// The next request is taken once the final response beat sits in the output
// register.
// No clearing pass is needed after reset: slot valid bits clear at once.
module price_time_order_book_top #(
   parameter int ORDER_SLOTS = pto_pkg::ORDER_SLOTS_DEF,
   parameter int PRICE_BITS  = pto_pkg::PRICE_BITS_DEF,
   parameter int QTY_BITS    = pto_pkg::QTY_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_cmd,
   input  logic        req_side,
   input  logic [31:0] req_order_id,
   input  logic [31:0] req_client_id,
   input  logic [31:0] req_price,
   input  logic [31:0] req_quantity,
   input  logic [6:0]  req_depth_levels,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_kind,
   output logic [31:0] rsp_order_id_res,
   output logic [31:0] rsp_client_id_res,
   output logic [31:0] rsp_price_res,
   output logic [31:0] rsp_quantity_res,
   output logic [6:0]  rsp_level_orders,
   output logic        rsp_found,
   output logic        rsp_bid_valid,
   output logic [31:0] rsp_best_bid_price,
   output logic        rsp_ask_valid,
   output logic [31:0] rsp_best_ask_price,
   output logic        rsp_last
);

   // command and status between sequencer and datapath
   pto_pkg::pto_cmd_type ctl;
   pto_pkg::pto_sts_type sts;

   // sequencer: scans, actions and response beats
   pto_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .ctl       (ctl)
   );

   // slot store, scan accumulators, result buffer and output register
   pto_dpath #(
      .ORDER_SLOTS (ORDER_SLOTS),
      .PRICE_BITS  (PRICE_BITS),
      .QTY_BITS    (QTY_BITS)
   ) u_dpath (
      .clock              (clock),
      .reset              (reset),
      .req_cmd            (req_cmd),
      .req_side           (req_side),
      .req_order_id       (req_order_id),
      .req_client_id      (req_client_id),
      .req_price          (req_price),
      .req_quantity       (req_quantity),
      .req_depth_levels   (req_depth_levels),
      .ctl                (ctl),
      .sts                (sts),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_kind           (rsp_kind),
      .rsp_order_id_res   (rsp_order_id_res),
      .rsp_client_id_res  (rsp_client_id_res),
      .rsp_price_res      (rsp_price_res),
      .rsp_quantity_res   (rsp_quantity_res),
      .rsp_level_orders   (rsp_level_orders),
      .rsp_found          (rsp_found),
      .rsp_bid_valid      (rsp_bid_valid),
      .rsp_best_bid_price (rsp_best_bid_price),
      .rsp_ask_valid      (rsp_ask_valid),
      .rsp_best_ask_price (rsp_best_ask_price),
      .rsp_last           (rsp_last)
   );

   // a taken request beat always makes the block busy next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request side not busy after accepting a beat");

   // an empty marker is always the only beat of its command
   a_empty_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == pto_pkg::KIND_EMPTY |-> rsp_last)
      else $error("empty marker not flagged last");

   // found only ever rides on a cancel result
   a_found_on_cancel: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_found |-> rsp_kind == pto_pkg::KIND_CANCEL)
      else $error("found set on a non-cancel beat");

   // absent bid side reports a zero price
   a_no_bid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_bid_valid |-> rsp_best_bid_price == 32'd0)
      else $error("best bid nonzero with no bid resting");

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// self-checking bench for the price-time order book: random and directed commands,
// predicted results compared beat by beat; depends on pto_pkg and price_time_order_book_top

module testbench;

   localparam int SLOTS = 64;
   localparam int WATCHDOG_LIMIT = 40000;
   localparam int HOLD_CYCLES = 400;

   typedef struct {
      logic [2:0]  cmd;
      logic        side;
      logic [31:0] oid;
      logic [31:0] cid;
      logic [31:0] price;
      logic [31:0] qty;
      logic [6:0]  levels;
   } order_cmd_type;

   typedef struct {
      logic [2:0]  kind;
      logic [31:0] oid;
      logic [31:0] cid;
      logic [31:0] price;
      logic [31:0] qty;
      logic [6:0]  count;
      logic        found;
      logic        bid_v;
      logic [31:0] bid_px;
      logic        ask_v;
      logic [31:0] ask_px;
      logic        last;
   } book_beat_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [2:0]  req_cmd = '0;
   logic        req_side = 1'b0;
   logic [31:0] req_order_id = '0;
   logic [31:0] req_client_id = '0;
   logic [31:0] req_price = '0;
   logic [31:0] req_quantity = '0;
   logic [6:0]  req_depth_levels = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b1;
   logic [2:0]  rsp_kind;
   logic [31:0] rsp_order_id_res, rsp_client_id_res, rsp_price_res, rsp_quantity_res;
   logic [6:0]  rsp_level_orders;
   logic        rsp_found, rsp_bid_valid, rsp_ask_valid, rsp_last;
   logic [31:0] rsp_best_bid_price, rsp_best_ask_price;

   // stall value seen at the rising edge, so the driver knows whether its beat went
   logic req_stall_q = 1'b1;

   price_time_order_book_top u_top (
      .clock, .reset,
      .req_valid, .req_stall, .req_cmd, .req_side, .req_order_id, .req_client_id,
      .req_price, .req_quantity, .req_depth_levels,
      .rsp_valid, .rsp_stall, .rsp_kind, .rsp_order_id_res, .rsp_client_id_res,
      .rsp_price_res, .rsp_quantity_res, .rsp_level_orders, .rsp_found,
      .rsp_bid_valid, .rsp_best_bid_price, .rsp_ask_valid, .rsp_best_ask_price,
      .rsp_last
   );

   // predicted copy of the slot store
   bit          bk_valid[SLOTS];
   bit          bk_side[SLOTS];
   bit [31:0]   bk_oid[SLOTS];
   bit [31:0]   bk_cid[SLOTS];
   bit [31:0]   bk_price[SLOTS];
   bit [31:0]   bk_left[SLOTS];
   bit [31:0]   bk_arrival[SLOTS];
   bit [31:0]   arrival_seq;

   order_cmd_type  pending_cmds[$];
   book_beat_type  expected_beats[$];
   book_beat_type  cur_batch[$];

   int  errors = 0;
   int  cmds_taken = 0;
   int  beats_seen = 0;
   int  fills_seen = 0;
   int  rejects_seen = 0;
   int  send_idle_pct = 6;
   int  recv_idle_pct = 58;
   int  hold_off = 0;         // receiver hold-off cycles still to run
   int  hold_req = 0;         // bumped by the stimulus to ask for a hold-off
   int  hold_ack = 0;         // hold-off requests already started
   int  quiet_cycles = 0;
   int unsigned id_pool[$];   // ids recently added, reused for cancels and duplicates

   // clock: 2 ns period
   initial begin
      forever #1 clock = ~clock;
   end

   function automatic bit ranks_better(bit sd, bit [31:0] a, bit [31:0] b);
      return sd ? (a < b) : (a > b);
   endfunction

   function automatic bit side_best(bit sd, output bit [31:0] px);
      bit any;
      any = 1'b0;
      px = '0;
      for (int i = 0; i < SLOTS; i++)
         if (bk_valid[i] && bk_side[i] == sd && (!any || ranks_better(sd, bk_price[i], px))) begin
            px = bk_price[i];
            any = 1'b1;
         end
      return any;
   endfunction

   function automatic void push_beat(logic [2:0] kind, logic [31:0] oid, logic [31:0] cid,
                                     logic [31:0] px, logic [31:0] qty, int cnt, int fnd);
      book_beat_type b;
      b = '{kind, oid, cid, px, qty, 7'(cnt), 1'(fnd), 1'b0, '0, 1'b0, '0, 1'b0};
      cur_batch.insert(cur_batch.size(), b);
   endfunction

   // apply one command to the predicted book and queue its result beats
   function automatic void book_apply(order_cmd_type c);
      int free_slot, pick;
      bit dup, hit, any, bv, av;
      bit [31:0] want, fill, bp, age, pick_age, lp, prev, bb, ba;
      bit [32:0] total;
      int cnt;
      cur_batch.delete();
      case (c.cmd)
         pto_pkg::CMD_ADD: begin
            free_slot = -1;
            dup = 1'b0;
            for (int i = 0; i < SLOTS; i++)
               if (bk_valid[i]) begin
                  if (bk_oid[i] == c.oid) dup = 1'b1;
               end else if (free_slot < 0) free_slot = i;
            if (dup || free_slot < 0 || c.qty == 0) begin
               push_beat(pto_pkg::KIND_ADD_REJ, c.oid, c.cid, c.price, c.qty, 0, 0);
            end else begin
               bk_valid[free_slot] = 1'b1;
               bk_side[free_slot] = c.side;
               bk_oid[free_slot] = c.oid;
               bk_cid[free_slot] = c.cid;
               bk_price[free_slot] = c.price;
               bk_left[free_slot] = c.qty;
               bk_arrival[free_slot] = arrival_seq;
               arrival_seq++;
               push_beat(pto_pkg::KIND_ADD_OK, c.oid, c.cid, c.price, c.qty, 0, 0);
            end
         end
         pto_pkg::CMD_CANCEL: begin
            hit = 1'b0;
            for (int i = 0; i < SLOTS; i++)
               if (bk_valid[i] && bk_oid[i] == c.oid) begin
                  bk_valid[i] = 1'b0;
                  hit = 1'b1;
               end
            push_beat(pto_pkg::KIND_CANCEL, c.oid, 0, 0, 0, 0, int'(hit));
         end
         pto_pkg::CMD_SWEEP_BID, pto_pkg::CMD_SWEEP_ASK: begin
            want = c.qty;
            while (want > 0 && cur_batch.size() < SLOTS) begin
               if (!side_best(c.cmd == pto_pkg::CMD_SWEEP_ASK, bp)) break;
               pick = -1;
               pick_age = 0;
               for (int i = 0; i < SLOTS; i++)
                  if (bk_valid[i] && bk_side[i] == (c.cmd == pto_pkg::CMD_SWEEP_ASK)
                      && bk_price[i] == bp) begin
                     age = arrival_seq - bk_arrival[i];
                     if (pick < 0 || age > pick_age) begin
                        pick = i;
                        pick_age = age;
                     end
                  end
               fill = (want < bk_left[pick]) ? want : bk_left[pick];
               want -= fill;
               bk_left[pick] -= fill;
               if (bk_left[pick] == 0) bk_valid[pick] = 1'b0;
               push_beat(pto_pkg::KIND_FILL, bk_oid[pick], bk_cid[pick], bp, fill, 0, 0);
            end
         end
         pto_pkg::CMD_DEPTH: begin
            prev = '0;
            while (cur_batch.size() < c.levels && cur_batch.size() < SLOTS) begin
               any = 1'b0;
               lp = '0;
               for (int i = 0; i < SLOTS; i++)
                  if (bk_valid[i] && bk_side[i] == c.side &&
                      (cur_batch.size() == 0 || ranks_better(c.side, prev, bk_price[i])))
                     if (!any || ranks_better(c.side, bk_price[i], lp)) begin
                        lp = bk_price[i];
                        any = 1'b1;
                     end
               if (!any) break;
               total = '0;
               cnt = 0;
               for (int i = 0; i < SLOTS; i++)
                  if (bk_valid[i] && bk_side[i] == c.side && bk_price[i] == lp) begin
                     total = total + bk_left[i];
                     if (total[32]) total = 33'h0_FFFF_FFFF;   // saturate level total
                     cnt++;
                  end
               push_beat(pto_pkg::KIND_DEPTH, 0, 0, lp, total[31:0], cnt, 0);
               prev = lp;
            end
         end
         default: ;
      endcase
      if (cur_batch.size() == 0) push_beat(pto_pkg::KIND_EMPTY, 0, 0, 0, 0, 0, 0);
      bv = side_best(1'b0, bb);
      av = side_best(1'b1, ba);
      foreach (cur_batch[k]) begin
         cur_batch[k].bid_v = bv;
         cur_batch[k].bid_px = bb;
         cur_batch[k].ask_v = av;
         cur_batch[k].ask_px = ba;
         cur_batch[k].last = (k == cur_batch.size() - 1);
         expected_beats.insert(expected_beats.size(), cur_batch[k]);
      end
   endfunction

   function automatic order_cmd_type make_cmd(logic [2:0] cmd, logic [31:0] sd,
                                              logic [31:0] oid, logic [31:0] cid,
                                              logic [31:0] px, logic [31:0] qty,
                                              logic [31:0] lv);
      order_cmd_type c;
      c = '{cmd, 1'(sd), oid, cid, px, qty, 7'(lv)};
      return c;
   endfunction

   function automatic void queue_cmd(order_cmd_type c);
      pending_cmds.insert(pending_cmds.size(), c);
   endfunction

   // mostly well-formed random command: clustered prices so levels stack and sweeps cross them
   function automatic order_cmd_type rand_cmd();
      order_cmd_type c;
      int sel;
      int unsigned oid;
      sel = $urandom_range(0, 99);
      c = make_cmd(pto_pkg::CMD_ADD, $urandom_range(0, 1), $urandom, $urandom,
                   $urandom_range(95, 105), $urandom_range(1, 50), $urandom_range(0, 8));
      if (sel < 3) c.price = $urandom;
      if (sel < 5) c.qty = $urandom;
      if (sel < 50) begin
         if (id_pool.size() > 0 && $urandom_range(0, 19) == 0)
            c.oid = id_pool[$urandom_range(0, id_pool.size() - 1)];   // duplicate id
         if ($urandom_range(0, 29) == 0) c.qty = 0;
         id_pool.insert(id_pool.size(), c.oid);
         if (id_pool.size() > 80) id_pool.delete(0);
      end else if (sel < 65) begin
         c.cmd = pto_pkg::CMD_CANCEL;
         if (id_pool.size() > 0 && $urandom_range(0, 4) != 0) begin
            oid = id_pool[$urandom_range(0, id_pool.size() - 1)];
            c.oid = oid;
         end
      end else if (sel < 80) begin
         c.cmd = $urandom_range(0, 1) ? pto_pkg::CMD_SWEEP_ASK : pto_pkg::CMD_SWEEP_BID;
         c.qty = $urandom_range(0, 9) == 0 ? 0 : $urandom_range(1, 120);
      end else if (sel < 97) begin
         c.cmd = pto_pkg::CMD_DEPTH;
         if ($urandom_range(0, 9) == 0) c.levels = 7'($urandom_range(0, 127));
      end else begin
         c.cmd = 3'($urandom_range(5, 7));   // unused command codes
      end
      return c;
   endfunction

   // driver: offers the head of the pending queue, idles at random, changes on falling edge
   always @(negedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall_q) begin
            // beat taken at the last rising edge
            pending_cmds.delete(0);
         end
         if (!req_valid || !req_stall_q) begin
            if (pending_cmds.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               req_valid <= 1'b1;
               req_cmd <= pending_cmds[0].cmd;
               req_side <= pending_cmds[0].side;
               req_order_id <= pending_cmds[0].oid;
               req_client_id <= pending_cmds[0].cid;
               req_price <= pending_cmds[0].price;
               req_quantity <= pending_cmds[0].qty;
               req_depth_levels <= pending_cmds[0].levels;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver: long hold-off on request, random stalls otherwise
   always @(negedge clock) begin
      if (!reset) begin
         if (hold_ack != hold_req) begin
            hold_ack <= hold_req;
            hold_off <= HOLD_CYCLES;
            rsp_stall <= 1'b1;
         end else if (hold_off > 0) begin
            rsp_stall <= 1'b1;
            hold_off <= hold_off - 1;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
         end
      end
   end

   // monitor: accepts and checks at the rising edge
   always @(posedge clock) begin
      book_beat_type e;
      if (reset) begin
         req_stall_q <= 1'b1;
      end else begin
         req_stall_q <= req_stall;
         quiet_cycles <= ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) ?
                         0 : quiet_cycles + 1;
         if (req_valid && !req_stall) begin
            book_apply(pending_cmds[0]);
            cmds_taken <= cmds_taken + 1;
         end
         if (rsp_valid && !rsp_stall) begin
            beats_seen <= beats_seen + 1;
            if (rsp_kind == pto_pkg::KIND_FILL) fills_seen <= fills_seen + 1;
            if (rsp_kind == pto_pkg::KIND_ADD_REJ) rejects_seen <= rejects_seen + 1;
            if (expected_beats.size() == 0) begin
               $error("unexpected beat kind %0d", rsp_kind);
               errors++;
            end else begin
               e = expected_beats[0];
               expected_beats.delete(0);
               if (rsp_kind !== e.kind) begin
                  $error("kind exp %0d got %0d", e.kind, rsp_kind); errors++;
               end
               if (rsp_order_id_res !== e.oid) begin
                  $error("order_id_res exp %0h got %0h", e.oid, rsp_order_id_res);
                  errors++;
               end
               if (rsp_client_id_res !== e.cid) begin
                  $error("client_id_res exp %0h got %0h", e.cid, rsp_client_id_res);
                  errors++;
               end
               if (rsp_price_res !== e.price) begin
                  $error("price_res exp %0d got %0d", e.price, rsp_price_res);
                  errors++;
               end
               if (rsp_quantity_res !== e.qty) begin
                  $error("quantity_res exp %0d got %0d", e.qty, rsp_quantity_res);
                  errors++;
               end
               if (rsp_level_orders !== e.count) begin
                  $error("level_orders exp %0d got %0d", e.count, rsp_level_orders);
                  errors++;
               end
               if (rsp_found !== e.found) begin
                  $error("found exp %0d got %0d", e.found, rsp_found); errors++;
               end
               if (rsp_bid_valid !== e.bid_v) begin
                  $error("bid_valid exp %0d got %0d", e.bid_v, rsp_bid_valid);
                  errors++;
               end
               if (rsp_best_bid_price !== e.bid_px) begin
                  $error("best_bid_price exp %0d got %0d", e.bid_px, rsp_best_bid_price);
                  errors++;
               end
               if (rsp_ask_valid !== e.ask_v) begin
                  $error("ask_valid exp %0d got %0d", e.ask_v, rsp_ask_valid);
                  errors++;
               end
               if (rsp_best_ask_price !== e.ask_px) begin
                  $error("best_ask_price exp %0d got %0d", e.ask_px, rsp_best_ask_price);
                  errors++;
               end
               if (rsp_last !== e.last) begin
                  $error("last exp %0d got %0d", e.last, rsp_last); errors++;
               end
            end
         end
      end
   end

   // watchdog: worst command is a 64-fill sweep or 64-level depth query, each fill or level a full scan, plus stalls
   always @(posedge clock) begin
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog expired with %0d beats outstanding", expected_beats.size());
         $display("[price_time_order_book_top] ERROR");
         $finish;
      end
   end

   // wait until the pending queue drains and every beat has arrived
   task automatic drain_book();
      while (pending_cmds.size() > 0 || req_valid || expected_beats.size() > 0)
         @(posedge clock);
   endtask

   initial begin
      for (int i = 0; i < SLOTS; i++) bk_valid[i] = 1'b0;
      arrival_seq = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: empty book cases, extremes, every command and kind
      queue_cmd(make_cmd(pto_pkg::CMD_SWEEP_BID, 0, 0, 0, 0, 10, 0));
      queue_cmd(make_cmd(pto_pkg::CMD_DEPTH, 1, 0, 0, 0, 0, 5));
      queue_cmd(make_cmd(pto_pkg::CMD_CANCEL, 0, 32'hDEAD_BEEF, 0, 0, 0, 0));
      queue_cmd(make_cmd(pto_pkg::CMD_ADD, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                         32'hFFFF_FFFF, 32'hFFFF_FFFF, 127));
      queue_cmd(make_cmd(pto_pkg::CMD_ADD, 0, 1, 11, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0));
      queue_cmd(make_cmd(pto_pkg::CMD_ADD, 1, 2, 22, 0, 5, 0));
      queue_cmd(make_cmd(pto_pkg::CMD_ADD, 1, 3, 33, 0, 7, 0));
      queue_cmd(make_cmd(pto_pkg::CMD_ADD, 1, 1, 44, 10, 5, 0));        // duplicate id
      queue_cmd(make_cmd(pto_pkg::CMD_ADD, 1, 9, 99, 10, 0, 0));        // zero lots
      queue_cmd(make_cmd(pto_pkg::CMD_DEPTH, 0, 0, 0, 0, 0, 64));       // saturating level
      queue_cmd(make_cmd(pto_pkg::CMD_DEPTH, 1, 0, 0, 0, 0, 0));        // zero levels
      queue_cmd(make_cmd(pto_pkg::CMD_SWEEP_ASK, 0, 0, 0, 0, 0, 0));    // zero lots
      queue_cmd(make_cmd(pto_pkg::CMD_SWEEP_ASK, 0, 0, 0, 0, 8, 0));    // oldest first
      queue_cmd(make_cmd(pto_pkg::CMD_SWEEP_ASK, 0, 0, 0, 0, 100, 0));  // partial sweep
      queue_cmd(make_cmd(pto_pkg::CMD_CANCEL, 0, 32'hFFFF_FFFF, 0, 0, 0, 0));
      queue_cmd(make_cmd(pto_pkg::CMD_SWEEP_BID, 1, 0, 0, 0, 32'hFFFF_FFFF, 0));
      queue_cmd(make_cmd(3'd5, 1, 1, 1, 1, 1, 1));
      queue_cmd(make_cmd(3'd7, 0, 0, 0, 0, 0, 0));
      // fill the store, then one add past full
      for (int i = 0; i < SLOTS + 1; i++)
         queue_cmd(make_cmd(pto_pkg::CMD_ADD, i % 2, 1000 + i, i, 50 + i % 3, 1, 0));
      queue_cmd(make_cmd(pto_pkg::CMD_DEPTH, 1, 0, 0, 0, 0, 64));
      queue_cmd(make_cmd(pto_pkg::CMD_SWEEP_BID, 0, 0, 0, 0, 32'hFFFF_FFFF, 0));
      queue_cmd(make_cmd(pto_pkg::CMD_SWEEP_ASK, 0, 0, 0, 0, 32'hFFFF_FFFF, 0));
      drain_book();

      // random phases with swapped idle rates, then no idling
      for (int ph = 0; ph < 3; ph++) begin
         send_idle_pct = (ph == 0) ? 6 : (ph == 1) ? 58 : 0;
         recv_idle_pct = (ph == 0) ? 58 : (ph == 1) ? 6 : 0;
         for (int n = 0; n < 130; n++) begin
            queue_cmd(rand_cmd());
            // long receiver hold-off while the sender keeps offering
            if (n == 40) begin
               hold_req++;
               while (pending_cmds.size() > 0) @(posedge clock);
            end
         end
         while (pending_cmds.size() > 0) @(posedge clock);
         drain_book();   // sender pauses until every beat is back
      end
      repeat (300) @(posedge clock);

      $display("covered %0d commands, %0d result beats, %0d fills, %0d rejected adds",
               cmds_taken, beats_seen, fills_seen, rejects_seen);
      if (errors == 0 && expected_beats.size() == 0) begin
         $display("[price_time_order_book_top] OK");
      end else begin
         $display("[price_time_order_book_top] ERROR");
      end
      $finish;
   end

endmodule
